/* src/teq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types, register indexes and width helpers for the three-band EQ.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int STATE_FRAC         = 8;
  localparam int GAIN_FRAC          = 12;
  localparam int CFG_BITS           = 16;
  localparam int CFG_IDX_BITS       = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_POLE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_POLE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_GAIN    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MID_GAIN    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_GAIN   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASTER_GAIN = 3'd5;

  localparam logic [CFG_BITS-1:0] LOW_POLE_RST  = 16'd63843;
  localparam logic [CFG_BITS-1:0] HIGH_POLE_RST = 16'd50443;
  localparam logic [CFG_BITS-1:0] GAIN_RST      = 16'd4096;

  typedef struct packed {
    logic [CFG_BITS-1:0] low_pole;
    logic [CFG_BITS-1:0] high_pole;
    logic [CFG_BITS-1:0] low_gain;
    logic [CFG_BITS-1:0] mid_gain;
    logic [CFG_BITS-1:0] high_gain;
    logic [CFG_BITS-1:0] master_gain;
  } teq_cfg_t;

  // width of a lane result before saturation
  function automatic int teq_y_bits(int sample_bits);
    int band_w;
    int prod_w;
    int sum_w;
    band_w = sample_bits + STATE_FRAC + 1;
    prod_w = band_w + CFG_BITS + 1 - GAIN_FRAC;
    sum_w  = prod_w + 2;
    return sum_w + CFG_BITS + 1 - GAIN_FRAC - STATE_FRAC;
  endfunction

endpackage

/* src/teq_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_filter
// One-pole lowpass: lp <= lp + floor((xs - lp) * (one - p) / one).
// ----------------------------------------------------------------------------
module teq_filter import teq_pkg::*; #(
  parameter int STATE_BITS     = SAMPLE_BITS_DEF + STATE_FRAC,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic signed [STATE_BITS-1:0] xs,
  input  logic        [CFG_BITS-1:0]   pole,
  output logic signed [STATE_BITS-1:0] lp
);

  localparam int KW = COEF_FRAC_BITS + 1;
  localparam int MW = (KW > CFG_BITS) ? KW : CFG_BITS;
  localparam int PW = STATE_BITS + 1 + KW + 1;
  localparam logic [KW-1:0] ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

  logic        [MW-1:0]         pole_m;
  logic        [MW-1:0]         one_m;
  logic        [KW-1:0]         k;
  logic signed [KW:0]           k_s;
  logic signed [STATE_BITS:0]   diff;
  logic signed [PW-1:0]         prod;
  logic signed [STATE_BITS-1:0] lp_next;

  assign pole_m = MW'(pole);
  assign one_m  = MW'(ONE);
  // a pole above one holds the state
  assign k      = (pole_m > one_m) ? '0 : KW'(one_m - pole_m);
  assign k_s    = $signed({1'b0, k});
  assign diff   = {xs[STATE_BITS-1], xs} - {lp[STATE_BITS-1], lp};
  assign prod   = PW'(diff) * PW'(k_s);
  assign lp_next = lp + STATE_BITS'(prod >>> COEF_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= '0;
    end else if (load) begin
      lp <= lp_next;
    end
  end

endmodule

/* src/teq_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_lane
// One channel: crossover filters, band gains, band sum and master gain.
// ----------------------------------------------------------------------------
module teq_lane import teq_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  logic                                      adv,
  input  teq_cfg_t                                  cfg,
  input  logic signed [SAMPLE_BITS-1:0]             sample,
  output logic signed [teq_y_bits(SAMPLE_BITS)-1:0] y
);

  localparam int ST = SAMPLE_BITS + STATE_FRAC;
  localparam int BW = ST + 1;
  localparam int GW = CFG_BITS + 1;
  localparam int PW = BW + GW - GAIN_FRAC;
  localparam int SW = PW + 2;
  localparam int YW = teq_y_bits(SAMPLE_BITS);

  logic signed [ST-1:0]    xs;
  logic signed [ST-1:0]    xs1;
  logic signed [ST-1:0]    lp_lo;
  logic signed [ST-1:0]    lp_hi;
  logic signed [BW-1:0]    low;
  logic signed [BW-1:0]    mid;
  logic signed [BW-1:0]    high;
  logic signed [GW-1:0]    gl;
  logic signed [GW-1:0]    gm;
  logic signed [GW-1:0]    gh;
  logic signed [GW-1:0]    gmaster;
  logic signed [BW+GW-1:0] pl;
  logic signed [BW+GW-1:0] pm;
  logic signed [BW+GW-1:0] ph;
  logic signed [PW-1:0]    bl;
  logic signed [PW-1:0]    bm;
  logic signed [PW-1:0]    bh;
  logic signed [SW-1:0]    sum;
  logic signed [SW+GW-1:0] ps;

  assign xs = {sample, {STATE_FRAC{1'b0}}};

  teq_filter #(.STATE_BITS(ST), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lo (
    .clk (clk),
    .rst (rst),
    .load(load),
    .xs  (xs),
    .pole(cfg.low_pole),
    .lp  (lp_lo)
  );

  teq_filter #(.STATE_BITS(ST), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_hi (
    .clk (clk),
    .rst (rst),
    .load(load),
    .xs  (xs),
    .pole(cfg.high_pole),
    .lp  (lp_hi)
  );

  assign gl      = $signed({1'b0, cfg.low_gain});
  assign gm      = $signed({1'b0, cfg.mid_gain});
  assign gh      = $signed({1'b0, cfg.high_gain});
  assign gmaster = $signed({1'b0, cfg.master_gain});

  assign low  = BW'(lp_lo);
  assign mid  = BW'(lp_hi) - BW'(lp_lo);
  assign high = BW'(xs1) - BW'(lp_hi);

  assign pl = (BW+GW)'(low) * (BW+GW)'(gl);
  assign pm = (BW+GW)'(mid) * (BW+GW)'(gm);
  assign ph = (BW+GW)'(high) * (BW+GW)'(gh);

  assign sum = SW'(bl) + SW'(bm) + SW'(bh);
  assign ps  = (SW+GW)'(sum) * (SW+GW)'(gmaster);

  always_ff @(posedge clk) begin
    if (adv) begin
      xs1 <= xs;
      bl  <= PW'(pl >>> GAIN_FRAC);
      bm  <= PW'(pm >>> GAIN_FRAC);
      bh  <= PW'(ph >>> GAIN_FRAC);
      y   <= YW'(ps >>> (GAIN_FRAC + STATE_FRAC));
    end
  end

endmodule

/* src/teq_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_merge
// Saturates both lane results and holds them in the output register.
// ----------------------------------------------------------------------------
module teq_merge import teq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      lane_valid,
  input  logic signed [teq_y_bits(SAMPLE_BITS)-1:0] yl,
  input  logic signed [teq_y_bits(SAMPLE_BITS)-1:0] yr,
  input  logic                                      result_ready,
  output logic                                      result_valid,
  output logic signed [SAMPLE_BITS-1:0]             left_out,
  output logic signed [SAMPLE_BITS-1:0]             right_out,
  output logic                                      adv
);

  localparam int YW = teq_y_bits(SAMPLE_BITS);
  localparam logic signed [YW-1:0] MAXV =
    $signed({{(YW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [YW-1:0] MINV = ~MAXV;
  localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OUT_MIN = ~OUT_MAX;

  logic signed [SAMPLE_BITS-1:0] left_next;
  logic signed [SAMPLE_BITS-1:0] right_next;

  function automatic logic [SAMPLE_BITS-1:0] sat(logic signed [YW-1:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v > MAXV) begin
      r = OUT_MAX;
    end else if (v < MINV) begin
      r = OUT_MIN;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  assign adv        = !result_valid || result_ready;
  assign left_next  = $signed(sat(yl));
  assign right_next = $signed(sat(yr));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= lane_valid;
    end
    if (adv) begin
      left_out  <= left_next;
      right_out <= right_next;
    end
  end

endmodule

/* src/three_band_equalizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_band_equalizer
// Stereo three-band equalizer with one-pole crossovers, band gains and a
// saturating master gain; one output pair per input pair.
// ----------------------------------------------------------------------------
// A sample pair passes the filter state, band product and lane result registers before it reaches the output register.
// The left and right lanes each run a four-stage pipeline (crossover filter
// update, band gains, band sum with master gain, saturation), so a new pair
// is taken every cycle while the output side keeps up; when the output
// register holds an untaken result the whole pipeline stalls and
// sample_ready drops. The filter feedback closes through one multiply per
// filter. Configuration writes are taken on any cycle (cfg_ready stays high)
// and must only happen while no sample is in flight.
// ----------------------------------------------------------------------------
module three_band_equalizer import teq_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  localparam int YW = teq_y_bits(SAMPLE_BITS);

  teq_cfg_t             cfg;
  logic                 adv;
  logic                 load;
  logic                 v1;
  logic                 v2;
  logic                 v3;
  logic signed [YW-1:0] yl;
  logic signed [YW-1:0] yr;

  assign cfg_ready    = 1'b1;
  assign sample_ready = adv;
  assign load         = sample_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_pole    <= LOW_POLE_RST;
      cfg.high_pole   <= HIGH_POLE_RST;
      cfg.low_gain    <= GAIN_RST;
      cfg.mid_gain    <= GAIN_RST;
      cfg.high_gain   <= GAIN_RST;
      cfg.master_gain <= GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_POLE:    cfg.low_pole    <= cfg_data;
        REG_HIGH_POLE:   cfg.high_pole   <= cfg_data;
        REG_LOW_GAIN:    cfg.low_gain    <= cfg_data;
        REG_MID_GAIN:    cfg.mid_gain    <= cfg_data;
        REG_HIGH_GAIN:   cfg.high_gain   <= cfg_data;
        REG_MASTER_GAIN: cfg.master_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= sample_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  teq_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_left (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .adv   (adv),
    .cfg   (cfg),
    .sample(left_sample),
    .y     (yl)
  );

  teq_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_right (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .adv   (adv),
    .cfg   (cfg),
    .sample(right_sample),
    .y     (yr)
  );

  teq_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk         (clk),
    .rst         (rst),
    .lane_valid  (v3),
    .yl          (yl),
    .yr          (yr),
    .result_ready(result_ready),
    .result_valid(result_valid),
    .left_out    (left_out),
    .right_out   (right_out),
    .adv         (adv)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-band equalizer. A driver process sends
// stereo sample pairs from a queue, a monitor predicts each output pair with
// a fixed-point crossover/gain model and compares every output transfer
// against it. Register settings change between phases, while idle.
// ----------------------------------------------------------------------------
module tb_top;
  import teq_pkg::*;

  localparam int SB             = SAMPLE_BITS_DEF;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 240;
  localparam int STALL_LIMIT    = 2000;
  localparam int SEGMENTS       = 6;
  localparam int SEGMENT_ITEMS  = 290;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint POLE_ONE   = 64'sd1 <<< COEF_FRAC_BITS_DEF;
  localparam logic signed [SB-1:0] RAIL_HI = SB'(SAMPLE_MAX);
  localparam logic signed [SB-1:0] RAIL_LO = SB'(SAMPLE_MIN);
  localparam logic signed [SB-1:0] S_ZERO  = SB'(0);
  localparam logic signed [SB-1:0] S_POS1  = SB'(1);
  localparam logic signed [SB-1:0] S_NEG1  = SB'(-1);

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } stereo_t;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
  logic [CFG_BITS-1:0]     cfg_data     = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_ready;
  logic signed [SB-1:0]    left_sample  = '0;
  logic signed [SB-1:0]    right_sample = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic signed [SB-1:0]    left_out;
  logic signed [SB-1:0]    right_out;

  three_band_equalizer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .left_out     (left_out),
    .right_out    (right_out)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // predictor copy of the register file and filter states
  logic [CFG_BITS-1:0] pole_low, pole_high;
  logic [CFG_BITS-1:0] gain_low, gain_mid, gain_high, gain_master;
  longint              lp_low [2];
  longint              lp_high [2];

  stereo_t pending_pairs [$];
  stereo_t expected_pairs [$];
  stereo_t drive_pair, predicted, want;

  logic sample_xfer = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   holds_asked = 0;
  int   holds_begun = 0;
  int   hold_left = 0;
  int   pairs_queued = 0;
  int   pairs_accepted = 0;
  int   results_checked = 0;
  int   cfg_writes = 0;
  int   settings_applied = 0;
  int   quiet_cycles = 0;
  int   errors = 0;

  function automatic longint mul_shift(longint a, longint c, int sh);
    return (a * c) >>> sh;
  endfunction

  function automatic logic signed [SB-1:0] eq_lane(int lane, logic signed [SB-1:0] x);
    longint xs, pl, ph, band_lo, band_mid, band_hi, acc, y;
    pl = (longint'(pole_low) > POLE_ONE) ? POLE_ONE : longint'(pole_low);
    ph = (longint'(pole_high) > POLE_ONE) ? POLE_ONE : longint'(pole_high);
    xs = longint'(x) <<< STATE_FRAC;
    lp_low[lane]  = lp_low[lane] + mul_shift(xs - lp_low[lane], POLE_ONE - pl,
                                             COEF_FRAC_BITS_DEF);
    lp_high[lane] = lp_high[lane] + mul_shift(xs - lp_high[lane], POLE_ONE - ph,
                                              COEF_FRAC_BITS_DEF);
    band_lo  = lp_low[lane];
    band_hi  = xs - lp_high[lane];
    band_mid = lp_high[lane] - lp_low[lane];
    acc = mul_shift(band_lo, gain_low, GAIN_FRAC) + mul_shift(band_mid, gain_mid, GAIN_FRAC)
        + mul_shift(band_hi, gain_high, GAIN_FRAC);
    y = mul_shift(acc, gain_master, GAIN_FRAC) >>> STATE_FRAC;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    else if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    return y[SB-1:0];
  endfunction

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_xfer) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_pair = pending_pairs.pop_front();
        sample_valid <= 1'b1;
        left_sample  <= drive_pair.left;
        right_sample <= drive_pair.right;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // output receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_begun != holds_asked) begin
      result_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      holds_begun <= holds_begun + 1;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: config tracking, prediction, checking, watchdog
  always @(posedge clk) begin
    if (rst) begin
      sample_xfer <= 1'b0;
      pole_low    = LOW_POLE_RST;
      pole_high   = HIGH_POLE_RST;
      gain_low    = GAIN_RST;
      gain_mid    = GAIN_RST;
      gain_high   = GAIN_RST;
      gain_master = GAIN_RST;
      lp_low[0]   = 0;
      lp_low[1]   = 0;
      lp_high[0]  = 0;
      lp_high[1]  = 0;
    end else begin
      sample_xfer <= sample_valid && sample_ready;
      if (result_valid && result_ready) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t unexpected output transfer: left %0d right %0d",
                   $time, left_out, right_out);
          errors++;
        end else begin
          want = expected_pairs.pop_front();
          if (left_out !== want.left) begin
            $display("%0t left_out mismatch: expected %0d, actual %0d",
                     $time, want.left, left_out);
            errors++;
          end
          if (right_out !== want.right) begin
            $display("%0t right_out mismatch: expected %0d, actual %0d",
                     $time, want.right, right_out);
            errors++;
          end
          results_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_POLE:    pole_low    = cfg_data;
          REG_HIGH_POLE:   pole_high   = cfg_data;
          REG_LOW_GAIN:    gain_low    = cfg_data;
          REG_MID_GAIN:    gain_mid    = cfg_data;
          REG_HIGH_GAIN:   gain_high   = cfg_data;
          REG_MASTER_GAIN: gain_master = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (sample_valid && sample_ready) begin
        predicted.left  = eq_lane(0, left_sample);
        predicted.right = eq_lane(1, right_sample);
        expected_pairs.push_back(predicted);
        pairs_accepted++;
      end
      if ((sample_valid && sample_ready) || (result_valid && result_ready)
          || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t timeout: no transfer for %0d cycles, %0d outputs outstanding",
                 $time, STALL_LIMIT, expected_pairs.size());
        $display("[three_band_equalizer] ERROR");
        $finish;
      end
    end
  end

  task automatic queue_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    stereo_t p;
    p.left  = l;
    p.right = r;
    pending_pairs.push_back(p);
    pairs_queued++;
  endtask

  // wait until every queued pair went out and came back, then let the pipe drain
  task automatic settle();
    while (pairs_accepted != pairs_queued || expected_pairs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input teq_cfg_t s, input bit with_spare);
    write_reg(REG_LOW_POLE, s.low_pole);
    write_reg(REG_HIGH_POLE, s.high_pole);
    write_reg(REG_LOW_GAIN, s.low_gain);
    write_reg(REG_MID_GAIN, s.mid_gain);
    write_reg(REG_HIGH_GAIN, s.high_gain);
    write_reg(REG_MASTER_GAIN, s.master_gain);
    if (with_spare) begin
      write_reg(REG_SPARE_A, CFG_BITS'($urandom));
      write_reg(REG_SPARE_B, CFG_BITS'($urandom));
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_BITS'($urandom_range(8192));
      default: return CFG_BITS'($urandom);
    endcase
  endfunction

  initial begin
    teq_cfg_t setting;
    stereo_t  p;
    p.left  = '0;
    p.right = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 57;

    // reset settings: unity gains, output tracks input
    queue_pair(RAIL_HI, RAIL_LO);
    queue_pair(RAIL_LO, RAIL_HI);
    queue_pair(RAIL_HI, RAIL_HI);
    queue_pair(RAIL_LO, RAIL_LO);
    queue_pair(S_ZERO, S_ZERO);
    queue_pair(S_POS1, S_NEG1);
    queue_pair(24'sh555555, 24'shAAAAAA);
    queue_pair(24'shAAAAAA, 24'sh555555);
    settle();

    // everything at full scale, plus writes to unused indexes
    setting = '{default: '1};
    apply_setting(setting, 1'b1);
    queue_pair(RAIL_HI, RAIL_LO);
    queue_pair(RAIL_LO, RAIL_HI);
    queue_pair(S_NEG1, S_POS1);
    queue_pair(S_ZERO, S_ZERO);
    settle();

    // zero poles pass the input straight to the low band, max gains saturate
    setting.low_pole  = '0;
    setting.high_pole = '0;
    apply_setting(setting, 1'b0);
    queue_pair(RAIL_HI, RAIL_LO);
    queue_pair(S_POS1, S_NEG1);
    settle();

    setting = '{default: '0};
    apply_setting(setting, 1'b0);
    queue_pair(RAIL_HI, RAIL_LO);
    queue_pair(24'sh123456, S_NEG1);
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 10; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      setting.low_pole    = pick_coef();
      setting.high_pole   = pick_coef();
      setting.low_gain    = pick_coef();
      setting.mid_gain    = pick_coef();
      setting.high_gain   = pick_coef();
      setting.master_gain = pick_coef();
      apply_setting(setting, seg % 2 == 0);
      if (seg == SEGMENTS - 1) holds_asked++;
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            p.left  = SB'($urandom);
            p.right = SB'($urandom);
          end
          4: begin
            p.left  = $urandom_range(1) ? RAIL_HI : RAIL_LO;
            p.right = $urandom_range(1) ? RAIL_HI : RAIL_LO;
          end
          5, 6: begin
            p.left  = SB'(int'($urandom_range(8191)) - 4096);
            p.right = SB'(int'($urandom_range(8191)) - 4096);
          end
          default: begin
            // slow drift from the previous pair, a band-limited signal
            p.left  = SB'(p.left + (int'($urandom_range(2047)) - 1024));
            p.right = SB'(p.right + (int'($urandom_range(2047)) - 1024));
          end
        endcase
        queue_pair(p.left, p.right);
      end
      settle();
    end

    $display("checked %0d output pairs across %0d register settings (%0d register writes)",
             results_checked, settings_applied + 1, cfg_writes);
    $display("covered rails, saturation, unused indexes, mixed idling and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (errors == 0 && expected_pairs.size() == 0)
      $display("[three_band_equalizer] OK");
    else
      $display("[three_band_equalizer] ERROR");
    $finish;
  end

endmodule
